FILE: rtl/ccu_pkg.sv
// Shared types and constants for the clique candidate update block.
package ccu_pkg;

  localparam int VERTEX_W    = 10;
  localparam int CONN_W      = 32;
  localparam int OUT_SCORE_W = 32;
  localparam int MODE_W      = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  // Q16.16 value of 1.0
  localparam logic [CONN_W-1:0] Q_ONE = 32'h0001_0000;

  // depth of the queue between the front and the back
  localparam int JOB_QUEUE_DEPTH = 2;

  // register index, taken from paddr[2]
  localparam logic REG_SCORE_MODE = 1'b0;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_SUM = 2'd0,
    MODE_MAX = 2'd1,
    MODE_DEG = 2'd2,
    MODE_STR = 2'd3
  } score_mode_e;

  typedef struct packed {
    logic                     op;
    logic [VERTEX_W-1:0]      vertex;
    logic                     neighbour_bit;
    logic signed [CONN_W-1:0] connection;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic                          kept;
    logic signed [OUT_SCORE_W-1:0] score;
    logic                          any_candidate;
    logic                          pass_end;
  } out_item_t;

  // classified request handed from the front to the back
  typedef struct packed {
    logic                     load;
    logic                     in_range;
    logic [VERTEX_W-1:0]      vertex;
    logic                     neighbour_bit;
    logic signed [CONN_W-1:0] connection;
    logic                     last;
  } job_t;

endpackage

FILE: rtl/ccu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ccu_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ccu_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module ccu_front #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ccu_pkg::in_item_t item_i,
  output logic              full_o,
  output logic              job_valid_o,
  output ccu_pkg::job_t     job_o,
  input  logic              job_pop_i
);

  localparam int DEPTH = ccu_pkg::JOB_QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int VW    = ccu_pkg::VERTEX_W;
  localparam int NW    = $clog2(MAX_VERTICES + 1);
  localparam int CW    = (VW > NW) ? VW : NW;

  ccu_pkg::job_t   queue_q [DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d;
  logic [PW-1:0]   rptr_q, rptr_d;
  logic [CNTW-1:0] count_q, count_d;
  logic            do_push, do_pop;
  ccu_pkg::job_t   job_new;

  assign full_o      = (count_q == CNTW'(DEPTH));
  assign job_valid_o = (count_q != '0);
  assign job_o       = queue_q[rptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = job_pop_i && job_valid_o;

  always_comb begin
    job_new.load          = (item_i.op == ccu_pkg::OP_LOAD);
    job_new.in_range      = (CW'(item_i.vertex) < CW'(MAX_VERTICES));
    job_new.vertex        = item_i.vertex;
    job_new.neighbour_bit = item_i.neighbour_bit;
    job_new.connection    = item_i.connection;
    job_new.last          = item_i.last;
  end

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNTW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      queue_q[wptr_q] <= job_new;
    end
  end

endmodule

FILE: rtl/ccu_back.sv
// Back end: table read-modify-write, score update, pass flag and result register.
module ccu_back #(
  parameter int MAX_VERTICES = 1024,
  parameter int SCORE_WIDTH  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ccu_pkg::score_mode_e mode_i,
  input  logic                 job_valid_i,
  input  ccu_pkg::job_t        job_i,
  output logic                 job_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output ccu_pkg::out_item_t   item_o
);

  localparam int SW  = SCORE_WIDTH;
  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int VW  = ccu_pkg::VERTEX_W;
  localparam int IW  = (AW > VW) ? AW : VW;
  localparam int OW  = ccu_pkg::OUT_SCORE_W;
  localparam int EW  = ((SW > ccu_pkg::CONN_W) ? SW : ccu_pkg::CONN_W) + 2;
  localparam int MW  = SW + 1;

  localparam logic signed [EW-1:0] SC_HI  = {{(EW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [EW-1:0] SC_LO  = ~SC_HI;
  localparam logic signed [EW-1:0] OUT_HI = {{(EW - OW + 1){1'b0}}, {(OW - 1){1'b1}}};
  localparam logic signed [EW-1:0] OUT_LO = ~OUT_HI;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  function automatic logic signed [SW-1:0] clamp_score(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] r;
    begin
      r = v;
      if (v > SC_HI) begin
        r = SC_HI;
      end else if (v < SC_LO) begin
        r = SC_LO;
      end
      return r[SW-1:0];
    end
  endfunction

  state_e             state_q, state_d;
  ccu_pkg::job_t      job_q;
  logic               out_valid_q, out_valid_d;
  ccu_pkg::out_item_t out_q, out_d;
  logic               pass_any_q, pass_any_d;

  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic [MW-1:0]        rdata;
  logic [MW-1:0]        wdata;
  logic                 we;

  logic                 old_bit;
  logic signed [SW-1:0] old_sc;
  logic signed [EW-1:0] old_x, conn_x, b_x, sum_x, neg_one_x, sc_x;
  logic signed [SW-1:0] sc;
  logic                 kept;
  logic                 any_now;

  assign raddr = AW'(IW'(job_i.vertex));
  assign waddr = AW'(IW'(job_q.vertex));

  ccu_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_VERTICES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i && (!out_valid_q || pop_i);
  assign empty_o   = !out_valid_q;
  assign item_o    = out_q;

  always_comb begin
    old_bit   = rdata[SW];
    old_sc    = $signed(rdata[SW-1:0]);
    old_x     = EW'(old_sc);
    conn_x    = EW'(job_q.connection);
    neg_one_x = -EW'($signed({1'b0, ccu_pkg::Q_ONE}));
    case (mode_i)
      ccu_pkg::MODE_SUM: b_x = conn_x;
      ccu_pkg::MODE_DEG: b_x = neg_one_x;
      ccu_pkg::MODE_STR: b_x = -conn_x;
      default:           b_x = '0;
    endcase
    sum_x = old_x + b_x;

    kept    = 1'b0;
    sc      = '0;
    any_now = pass_any_q;
    we      = 1'b0;
    if (job_q.in_range) begin
      we = (state_q == ST_EXEC);
      if (job_q.load) begin
        kept = job_q.neighbour_bit;
        sc   = clamp_score(conn_x);
      end else begin
        kept = old_bit & job_q.neighbour_bit;
        if (kept) begin
          any_now = 1'b1;
          if (mode_i == ccu_pkg::MODE_MAX) begin
            sc = (conn_x > old_x) ? clamp_score(conn_x) : old_sc;
          end else begin
            sc = clamp_score(sum_x);
          end
        end else if (mode_i == ccu_pkg::MODE_DEG || mode_i == ccu_pkg::MODE_STR) begin
          sc = clamp_score(neg_one_x);
        end
      end
    end
    wdata = {kept, sc};

    sc_x = EW'(sc);
    if (sc_x > OUT_HI) begin
      sc_x = OUT_HI;
    end else if (sc_x < OUT_LO) begin
      sc_x = OUT_LO;
    end
    out_d.kept          = kept;
    out_d.score         = sc_x[OW-1:0];
    out_d.any_candidate = any_now;
    out_d.pass_end      = job_q.last;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    pass_any_d  = pass_any_q;
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (job_pop_o) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        pass_any_d  = job_q.last ? 1'b0 : any_now;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pass_any_q  <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pass_any_q  <= pass_any_d;
      if (state_q == ST_EXEC) begin
        out_q <= out_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
  end

endmodule

FILE: rtl/clique_candidate_update.sv
// Top level of the clique candidate update block: config register, front and back.
//
// Requests enter a two-entry queue in the front end, which decodes the operation and
// checks the vertex range. The back end takes one request at a time: the table entry
// is read from the RAM as the request leaves the queue, and in the execute state it is
// updated, written back and loaded into the result register. A new request is taken
// only after the execute state and while the result register is empty or being popped.
// The table RAM has no reset; entries read before they are first loaded or updated
// return undefined data. score_mode is written over the APB port at address 0 and
// should only change while the block is idle.
module clique_candidate_update #(
  parameter int MAX_VERTICES = 1024,
  parameter int SCORE_WIDTH  = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  input  ccu_pkg::in_item_t                push_data_i,
  output logic                             full,
  input  logic                             pop,
  output logic                             empty,
  output ccu_pkg::out_item_t               pop_data_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ccu_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [ccu_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [ccu_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  ccu_pkg::score_mode_e score_mode_q, score_mode_d;
  logic                 cfg_write;
  logic                 job_valid;
  logic                 job_pop;
  ccu_pkg::job_t        job;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    score_mode_d = score_mode_q;
    if (cfg_write && paddr[2] == ccu_pkg::REG_SCORE_MODE) begin
      score_mode_d = ccu_pkg::score_mode_e'(pwdata[ccu_pkg::MODE_W-1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ccu_pkg::REG_SCORE_MODE) begin
      prdata = ccu_pkg::CFG_DATA_W'(score_mode_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_mode_q <= ccu_pkg::MODE_SUM;
    end else begin
      score_mode_q <= score_mode_d;
    end
  end

  ccu_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (push_data_i),
    .full_o      (full),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  ccu_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .SCORE_WIDTH  (SCORE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (score_mode_q),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .item_o      (pop_data_o)
  );

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the clique candidate update block.
`timescale 1ns / 100ps

module testbench;
  import ccu_pkg::*;

  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          PHASE_ITEMS    = 240;
  localparam longint      Q_MAX          = 64'sd2147483647;
  localparam longint      Q_MIN          = -64'sd2147483648;
  localparam out_item_t   NO_LIT         = '0;

  typedef struct {
    score_mode_e mode;
    in_item_t    req;
    bit          lit;
    out_item_t   want;
  } dir_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  push        = 1'b0;
  in_item_t              push_data_i = '0;
  logic                  full;
  logic                  pop         = 1'b0;
  logic                  empty;
  out_item_t             pop_data_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr       = '0;
  logic [CFG_DATA_W-1:0] pwdata      = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // predicted table state
  bit          cand_bit    [1024];
  longint      table_score [1024];
  bit          pass_any_q  = 1'b0;
  score_mode_e cfg_mode    = MODE_SUM;

  bit          loaded [1024];
  out_item_t   pending_results [$];
  bit          lit_on   = 1'b0;
  out_item_t   lit_want = '0;
  int          mismatches  = 0;
  int          sent_count  = 0;
  int unsigned quiet_cycles = 0;
  bit          tx_idle_en  = 1'b1;
  bit          rx_idle_en  = 1'b1;
  bit          rx_hold_req = 1'b0;

  score_mode_e phase_mode [8] = '{MODE_STR, MODE_SUM, MODE_MAX, MODE_DEG,
                                  MODE_SUM, MODE_STR, MODE_MAX, MODE_DEG};

  dir_row_t dir_rows [22] = '{
    '{MODE_SUM, '{OP_LOAD,   10'd0,    1'b1, 32'h7FFF_FFFF, 1'b0}, 1'b1,
      '{1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{MODE_SUM, '{OP_UPDATE, 10'd0,    1'b1, 32'h0000_0001, 1'b0}, 1'b1,
      '{1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0}},
    '{MODE_SUM, '{OP_LOAD,   10'd1023, 1'b1, 32'h8000_0000, 1'b1}, 1'b1,
      '{1'b1, 32'h8000_0000, 1'b1, 1'b1}},
    '{MODE_SUM, '{OP_UPDATE, 10'd1023, 1'b1, 32'h8000_0000, 1'b0}, 1'b0, NO_LIT},
    '{MODE_SUM, '{OP_UPDATE, 10'd1023, 1'b0, 32'h0000_0005, 1'b1}, 1'b0, NO_LIT},
    '{MODE_SUM, '{OP_UPDATE, 10'd1023, 1'b1, 32'h0000_1234, 1'b0}, 1'b1,
      '{1'b0, 32'h0000_0000, 1'b0, 1'b0}},
    '{MODE_MAX, '{OP_LOAD,   10'd5,    1'b1, 32'h0001_0000, 1'b0}, 1'b1,
      '{1'b1, 32'h0001_0000, 1'b0, 1'b0}},
    '{MODE_MAX, '{OP_UPDATE, 10'd5,    1'b1, 32'h0002_0000, 1'b0}, 1'b0, NO_LIT},
    '{MODE_MAX, '{OP_UPDATE, 10'd5,    1'b1, 32'h8000_0000, 1'b0}, 1'b0, NO_LIT},
    '{MODE_MAX, '{OP_UPDATE, 10'd5,    1'b0, 32'h7FFF_FFFF, 1'b1}, 1'b0, NO_LIT},
    '{MODE_DEG, '{OP_LOAD,   10'd2,    1'b1, 32'h8000_0000, 1'b0}, 1'b1,
      '{1'b1, 32'h8000_0000, 1'b0, 1'b0}},
    '{MODE_DEG, '{OP_UPDATE, 10'd2,    1'b1, 32'h0000_0000, 1'b0}, 1'b0, NO_LIT},
    '{MODE_DEG, '{OP_UPDATE, 10'd2,    1'b0, 32'hFFFF_FFFF, 1'b0}, 1'b1,
      '{1'b0, 32'hFFFF_0000, 1'b1, 1'b0}},
    '{MODE_DEG, '{OP_LOAD,   10'd3,    1'b1, 32'h0000_8000, 1'b0}, 1'b0, NO_LIT},
    '{MODE_DEG, '{OP_UPDATE, 10'd3,    1'b1, 32'h7FFF_FFFF, 1'b0}, 1'b0, NO_LIT},
    '{MODE_STR, '{OP_LOAD,   10'd4,    1'b1, 32'h7FFF_FFF0, 1'b0}, 1'b0, NO_LIT},
    '{MODE_STR, '{OP_UPDATE, 10'd4,    1'b1, 32'h8000_0000, 1'b0}, 1'b1,
      '{1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0}},
    '{MODE_STR, '{OP_LOAD,   10'd6,    1'b1, 32'h8000_0010, 1'b0}, 1'b0, NO_LIT},
    '{MODE_STR, '{OP_UPDATE, 10'd6,    1'b1, 32'h7FFF_FFFF, 1'b0}, 1'b0, NO_LIT},
    '{MODE_STR, '{OP_UPDATE, 10'd6,    1'b1, 32'h8000_0000, 1'b0}, 1'b0, NO_LIT},
    '{MODE_STR, '{OP_UPDATE, 10'd4,    1'b0, 32'h0000_0000, 1'b1}, 1'b1,
      '{1'b0, 32'hFFFF_0000, 1'b1, 1'b1}},
    '{MODE_STR, '{OP_LOAD,   10'd512,  1'b0, 32'h0000_0000, 1'b1}, 1'b1,
      '{1'b0, 32'h0000_0000, 1'b0, 1'b1}}
  };

  clique_candidate_update u_dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic longint clamp_q(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  // one table read-modify-write; returns the result the block should give
  function automatic out_item_t grow_step(in_item_t req);
    out_item_t res;
    longint    conn;
    longint    prev;
    longint    sc;
    bit        keep;
    conn = longint'($signed(req.connection));
    prev = table_score[req.vertex];
    if (req.op == OP_LOAD) begin
      keep = req.neighbour_bit;
      sc   = conn;
    end else begin
      keep = cand_bit[req.vertex] & req.neighbour_bit;
      if (keep) begin
        pass_any_q = 1'b1;
        case (cfg_mode)
          MODE_SUM: sc = clamp_q(prev + conn);
          MODE_MAX: sc = (conn > prev) ? conn : prev;
          MODE_DEG: sc = clamp_q(prev - longint'(Q_ONE));
          default:  sc = clamp_q(prev - conn);
        endcase
      end else begin
        sc = (cfg_mode == MODE_SUM || cfg_mode == MODE_MAX) ? 0 : -longint'(Q_ONE);
      end
    end
    cand_bit[req.vertex]    = keep;
    table_score[req.vertex] = sc;
    res.kept          = keep;
    res.score         = sc[31:0];
    res.any_candidate = pass_any_q;
    res.pass_end      = req.last;
    if (req.last) pass_any_q = 1'b0;
    return res;
  endfunction

  function automatic void note_mismatch(string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endfunction

  function automatic logic [31:0] rand_conn();
    case ($urandom_range(4))
      0: case ($urandom_range(3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return '0;
        default: return '1;
      endcase
      1: return $urandom_range(1) ? (32'($urandom_range(15)) << 16)
                                  : -(32'($urandom_range(15)) << 16);
      2: return ($urandom_range(1) ? 32'h7FFF_0000 : 32'h8000_0000) + $urandom_range(65535);
      default: return $urandom();
    endcase
  endfunction

  // request and result scoreboard
  always @(posedge clk_i) begin : mon
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      if (push && !full) begin
        want = grow_step(push_data_i);
        if (lit_on) want = lit_want;
        pending_results.insert(pending_results.size(), want);
      end
      if (pop && !empty) begin
        got = pop_data_o;
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("unexpected result kept=%0b score=%h any=%0b end=%0b",
                                  got.kept, got.score, got.any_candidate, got.pass_end));
        end else begin
          want = pending_results.pop_front();
          if (got.kept !== want.kept || got.score !== want.score ||
              got.any_candidate !== want.any_candidate || got.pass_end !== want.pass_end) begin
            note_mismatch($sformatf(
              "exp kept=%0b score=%h any=%0b end=%0b, got kept=%0b score=%h any=%0b end=%0b",
              want.kept, want.score, want.any_candidate, want.pass_end,
              got.kept, got.score, got.any_candidate, got.pass_end));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        pop <= 1'b0;
        rx_hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (rx_idle_en && $urandom_range(99) < 22) begin
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_request(in_item_t req, bit lit, out_item_t want);
    while (tx_idle_en && $urandom_range(99) < 22) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    push_data_i <= req;
    lit_on      <= lit;
    lit_want    <= want;
    if (req.op == OP_LOAD) loaded[req.vertex] = 1'b1;
    do @(posedge clk_i); while (full);
    sent_count++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_access(bit wr, score_mode_e m);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_SCORE_MODE, 2'b00};
    pwdata  <= CFG_DATA_W'(m);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (wr) begin
      cfg_mode = m;
    end else if (prdata !== CFG_DATA_W'(m)) begin
      note_mismatch($sformatf("score_mode read exp %h got %h", CFG_DATA_W'(m), prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(score_mode_e m);
    cfg_access(1'b1, m);
    cfg_access(1'b0, m);
  endtask

  // load pass over a small vertex set, then one to five newcomer passes over it;
  // now and then a burst of loose requests with random pass ends
  task automatic run_episode();
    int          n;
    int          rounds;
    int unsigned vs [$];
    in_item_t    req;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 4)) begin
        req.vertex        = 10'($urandom_range(1023));
        req.op            = (loaded[req.vertex] && $urandom_range(1)) ? OP_UPDATE : OP_LOAD;
        req.neighbour_bit = 1'($urandom_range(1));
        req.connection    = rand_conn();
        req.last          = 1'($urandom_range(1));
        send_request(req, 1'b0, NO_LIT);
      end
      return;
    end
    n = $urandom_range(1, 12);
    repeat (n) vs.insert(vs.size(), $urandom_range(1023));
    rounds = $urandom_range(1, 5);
    for (int r = 0; r <= rounds; r++) begin
      foreach (vs[i]) begin
        req.op            = (r == 0) ? OP_LOAD : OP_UPDATE;
        req.vertex        = 10'(vs[i]);
        req.neighbour_bit = ($urandom_range(99) < ((r == 0) ? 85 : 75));
        req.connection    = rand_conn();
        req.last          = (i == n - 1);
        send_request(req, 1'b0, NO_LIT);
      end
    end
  endtask

  initial begin
    int target;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);
    cfg_access(1'b0, MODE_SUM);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != cfg_mode) begin
        wait_drained();
        cfg_write(dir_rows[i].mode);
      end
      send_request(dir_rows[i].req, dir_rows[i].lit, dir_rows[i].want);
    end

    foreach (phase_mode[ph]) begin
      wait_drained();
      cfg_write(phase_mode[ph]);
      tx_idle_en = (ph != 1);
      rx_idle_en = (ph != 1);
      if (ph == 3) rx_hold_req = 1'b1;
      target = sent_count + PHASE_ITEMS;
      while (sent_count < target) run_episode();
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ccu_pkg.sv
rtl/ccu_ram.sv
rtl/ccu_front.sv
rtl/ccu_back.sv
rtl/clique_candidate_update.sv
verif/testbench.sv
